@@ hw/rtl/fcd_pkg.sv @@
// Shared types, constants and calendar tables for the fixed-calendar date unit.
package fcd_pkg;

  // Command codes.
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_SUB  = 2'd1;
  localparam logic [1:0] CMD_DIFF = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam int DAYS_PER_YEAR = 365;

  // Length of a month, indexed by month number 1..12; other codes give zero.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    begin
      case (m)
        4'd2: r = 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

  // Days in the months before month m (1..12).
  function automatic logic [8:0] month_cum(input logic [3:0] m);
    logic [8:0] r;
    begin
      case (m)
        4'd1: r = 9'd0;    4'd2: r = 9'd31;   4'd3: r = 9'd59;
        4'd4: r = 9'd90;   4'd5: r = 9'd120;  4'd6: r = 9'd151;
        4'd7: r = 9'd181;  4'd8: r = 9'd212;  4'd9: r = 9'd243;
        4'd10: r = 9'd273; 4'd11: r = 9'd304; 4'd12: r = 9'd334;
        default: r = 9'd0;
      endcase
      return r;
    end
  endfunction

  // Month of a zero-based day of year (0..364).
  function automatic logic [3:0] doy_month(input logic [8:0] doy);
    logic [3:0] r;
    begin
      r = 4'd1;
      for (int k = 2; k <= 12; k++) begin
        if (doy >= month_cum(4'(k))) r = 4'(k);
      end
      return r;
    end
  endfunction

  // Checks passed from the front stage.
  typedef struct packed {
    logic       vld;
    logic [1:0] cmd;
    logic [1:0] status;
  } fcd_ctl_t;

endpackage

@@ hw/rtl/fixed_calendar_date_alu.sv @@
// Top level of the fixed-calendar date unit.
// Five-stage pipeline (check and serialise, offset add, year divide, remainder fix,
// month lookup); one request enters per cycle when the output is free, and each
// result is registered at each stage in that order. The depth is set
// by the reciprocal multiply that splits a serial day into year and day of year.
module fixed_calendar_date_alu import fcd_pkg::*; #(
  parameter int OFFSET_WIDTH = 16,
  parameter int YEAR_MAX     = 9999
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  input  logic [15:0] offset_days,
  input  logic [4:0]  other_day,
  input  logic [3:0]  other_month,
  input  logic [13:0] other_year,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  result_day,
  output logic [3:0]  result_month,
  output logic [13:0] result_year,
  output logic signed [22:0] day_difference,
  output logic        is_equal,
  output logic        is_less,
  output logic        is_greater,
  output logic [1:0]  status
);

  localparam int OW = (OFFSET_WIDTH < 16) ? OFFSET_WIDTH : 16;
  localparam int SW = 41;

  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: checks and serial days.
  logic [1:0]  st1_w;
  logic [23:0] sa_w, sb_w;
  fcd_serial #(.YEAR_MAX(YEAR_MAX)) u_serial (
    .command, .day, .month, .year, .other_day, .other_month, .other_year,
    .status(st1_w), .serial_a(sa_w), .serial_b(sb_w));

  fcd_ctl_t c1, c2, c3, c4;
  logic [23:0] sa1, sb1;
  logic [15:0] off1;
  logic [4:0]  d1, d2, d3, d4;
  logic [3:0]  m1, m2, m3, m4;
  logic [13:0] y1, y2, y3, y4;

  always_ff @(posedge clk) begin
    if (rst) c1.vld <= 1'b0;
    else if (adv) c1.vld <= in_valid;
    if (adv) begin
      c1.cmd <= command; c1.status <= st1_w;
      sa1 <= sa_w; sb1 <= sb_w;
      off1 <= offset_days & 16'((17'd1 << OW) - 17'd1);
      d1 <= day; m1 <= month; y1 <= year;
    end
  end

  // Stage 2: offset arithmetic and the difference.
  logic signed [SW-1:0] s2;
  logic signed [24:0]   dv2;
  always_ff @(posedge clk) begin
    if (rst) c2.vld <= 1'b0;
    else if (adv) c2.vld <= c1.vld;
    if (adv) begin
      c2.cmd <= c1.cmd; c2.status <= c1.status;
      d2 <= d1; m2 <= m1; y2 <= y1;
      s2 <= (c1.cmd == CMD_ADD) ? SW'(sa1) + SW'(off1) : SW'(sa1) - SW'(off1);
      dv2 <= $signed({1'b0, sa1}) - $signed({1'b0, sb1});
    end
  end

  // Stage 3: year by reciprocal multiply; a negative serial day is flagged later.
  logic [15:0] q_w;
  logic [15:0] q3;
  logic signed [SW-1:0] s3;
  logic signed [24:0] dv3;
  fcd_split u_split (.serial(s2[40] ? 24'd0 : s2[23:0]), .quot_est(q_w));
  always_ff @(posedge clk) begin
    if (rst) c3.vld <= 1'b0;
    else if (adv) c3.vld <= c2.vld;
    if (adv) begin
      c3.cmd <= c2.cmd; c3.status <= c2.status;
      d3 <= d2; m3 <= m2; y3 <= y2;
      q3 <= q_w; s3 <= s2; dv3 <= dv2;
    end
  end

  // Stage 4: day of year as the remainder, and the negative-day flag.
  logic [24:0] rem_w;
  logic [8:0]  doy4;
  logic [15:0] yr4;
  logic        neg4;
  logic signed [24:0] dv4;
  always_comb begin
    rem_w = 25'(s3[23:0]) - 25'(q3) * 25'(DAYS_PER_YEAR);
  end
  always_ff @(posedge clk) begin
    if (rst) c4.vld <= 1'b0;
    else if (adv) c4.vld <= c3.vld;
    if (adv) begin
      c4.cmd <= c3.cmd; c4.status <= c3.status;
      d4 <= d3; m4 <= m3; y4 <= y3;
      doy4 <= rem_w[8:0]; yr4 <= q3; neg4 <= s3[40]; dv4 <= dv3;
    end
  end

  // Stage 5: month lookup and result assembly.
  logic [3:0]  mo_w;
  logic [4:0]  result_day_next;
  logic [3:0]  result_month_next;
  logic [13:0] result_year_next;
  logic signed [22:0] day_difference_next;
  logic        is_equal_next, is_less_next, is_greater_next;
  logic [1:0]  status_next;
  assign mo_w = doy_month(doy4);
  always_comb begin
    result_day_next     = d4;
    result_month_next   = m4;
    result_year_next    = y4;
    day_difference_next = '0;
    is_equal_next       = 1'b0;
    is_less_next        = 1'b0;
    is_greater_next     = 1'b0;
    status_next         = c4.status;
    if (c4.status == ST_OK) begin
      if (c4.cmd == CMD_ADD || c4.cmd == CMD_SUB) begin
        if (neg4 || 32'(yr4) > 32'(YEAR_MAX)) status_next = ST_RANGE;
        else begin
          result_year_next  = yr4[13:0];
          result_month_next = mo_w;
          result_day_next   = 5'(doy4 - month_cum(mo_w) + 9'd1);
        end
      end else if (c4.cmd == CMD_DIFF) begin
        if (dv4 > 25'sd4194303) day_difference_next = 23'sh3FFFFF;
        else if (dv4 < -25'sd4194304) day_difference_next = 23'sh400000;
        else day_difference_next = dv4[22:0];
        is_equal_next   = dv4 == 25'sd0;
        is_less_next    = dv4 < 25'sd0;
        is_greater_next = dv4 > 25'sd0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= c4.vld;
    if (adv) begin
      result_day <= result_day_next; result_month <= result_month_next;
      result_year <= result_year_next;
      day_difference <= day_difference_next;
      is_equal <= is_equal_next; is_less <= is_less_next; is_greater <= is_greater_next;
      status <= status_next;
    end
  end

  // At most one comparison flag is raised.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({is_equal, is_less, is_greater})) else $error("flags clash");
  // Flags only with good status.
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !is_equal && !is_less && !is_greater)
    else $error("flags with bad status");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(day_difference) && $stable(status))
    else $error("result changed in stall");

endmodule

@@ hw/rtl/fcd_serial.sv @@
// Front stage: date checks and conversion of both dates to serial days.
module fcd_serial import fcd_pkg::*; #(
  parameter int YEAR_MAX = 9999
) (
  input  logic [1:0]  command,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  input  logic [4:0]  other_day,
  input  logic [3:0]  other_month,
  input  logic [13:0] other_year,
  output logic [1:0]  status,
  output logic [23:0] serial_a,
  output logic [23:0] serial_b
);

  logic ok_a, ok_b, yr_a, yr_b;

  // Validity of each date and its year range, the serial days and the status.
  always_comb begin
    ok_a = (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) && (day <= month_len(month));
    ok_b = (other_month >= 4'd1) && (other_month <= 4'd12) && (other_day >= 5'd1)
           && (other_day <= month_len(other_month));
    yr_a = 32'(year) <= 32'(YEAR_MAX);
    yr_b = 32'(other_year) <= 32'(YEAR_MAX);
    serial_a = 24'(year) * 24'(DAYS_PER_YEAR) + 24'(month_cum(month)) + 24'(day) - 24'd1;
    serial_b = 24'(other_year) * 24'(DAYS_PER_YEAR) + 24'(month_cum(other_month))
               + 24'(other_day) - 24'd1;
    status = ST_OK;
    if (command == CMD_ADD || command == CMD_SUB) begin
      if (!ok_a) status = ST_BAD;
      else if (!yr_a) status = ST_RANGE;
    end else if (command == CMD_DIFF) begin
      if (!ok_a || !ok_b) status = ST_BAD;
      else if (!yr_a || !yr_b) status = ST_RANGE;
    end
  end

endmodule

@@ hw/rtl/fcd_split.sv @@
// Back stage: serial day to year by reciprocal multiplication.
module fcd_split import fcd_pkg::*; (
  input  logic [23:0] serial,
  output logic [15:0] quot_est
);

  // floor(s/365) = s * ceil(2^33/365) >> 33, exact for every s below 2^24.
  localparam logic [24:0] RECIP = 25'd23534068;
  logic [48:0] prod;

  always_comb begin
    prod     = 49'(serial) * 49'(RECIP);
    quot_est = prod[48:33];
  end

endmodule
